// ===== design/sorted_priority_queue_assert.svh =====
// assertion macros for the sorted priority queue
// clocked on i_clk, disabled while i_rst_n is low; no other dependencies
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sorted priority queue assertion failed")
`define SPQ_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("sorted priority queue forbidden condition seen")
`else
`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== design/spq_pkg.sv =====
// shared types and constants of the sorted priority queue
// no dependencies
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int ELEM_W   = 32;
    localparam int PRIO_W   = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        F_INSERT = 2'd0,
        F_REMOVE = 2'd1,
        F_CHANGE = 2'd2,
        F_PEEK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic        [ELEM_W-1:0] value;
        logic signed [PRIO_W-1:0] prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [ELEM_W-1:0] head;
        logic              empty;
        logic [CNT_W-1:0]  count;
        t_status           status;
    } t_result;

endpackage

// ===== design/spq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module spq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/spq_seq.sv =====
// operation sequencer: walks the sorted entry memory one entry per cycle
// depends on spq_pkg and sorted_priority_queue_assert.svh
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"

module spq_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_func,
    input  logic [spq_pkg::ELEM_W-1:0] i_elem,
    input  logic [spq_pkg::PRIO_W-1:0] i_prio,
    output spq_pkg::t_ram_req          o_ram,
    input  spq_pkg::t_entry            i_rdata,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output spq_pkg::t_result           o_res
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INS0 = 8'b0000_0010,
        S_INS  = 8'b0000_0100,
        S_PUT  = 8'b0000_1000,
        S_SRCH = 8'b0001_0000,
        S_DEL  = 8'b0010_0000,
        S_HEAD = 8'b0100_0000,
        S_RES  = 8'b1000_0000
    } t_state;

    t_state                           r_state, n_state;
    logic [spq_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [spq_pkg::ADDR_W-1:0]       r_k, n_k;
    spq_pkg::t_status                 r_status, n_status;
    spq_pkg::t_func                   r_func, n_func;
    logic [spq_pkg::ELEM_W-1:0]       r_val, n_val;
    logic signed [spq_pkg::PRIO_W-1:0] r_pr, n_pr;

    logic [spq_pkg::CNT_W-1:0] k_inc;
    logic                      more;
    spq_pkg::t_entry           new_entry;

    assign k_inc     = spq_pkg::CNT_W'(r_k) + spq_pkg::CNT_W'(1);
    assign more      = (k_inc < r_cnt);
    assign new_entry = '{value: r_val, prio: r_pr};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_status = r_status;
        n_func   = r_func;
        n_val    = r_val;
        n_pr     = r_pr;
        o_ram    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func   = spq_pkg::t_func'(i_func);
                    n_val    = i_elem;
                    n_pr     = i_prio;
                    n_status = spq_pkg::ST_OK;
                    n_state  = S_HEAD;
                    case (spq_pkg::t_func'(i_func))
                        spq_pkg::F_INSERT: begin
                            if (r_cnt == spq_pkg::CAP_CNT) begin
                                n_status = spq_pkg::ST_FULL;
                            end else begin
                                n_state = S_INS0;
                            end
                        end
                        spq_pkg::F_REMOVE: begin
                            if (r_cnt == '0) begin
                                n_status = spq_pkg::ST_EMPTY;
                            end else if (r_cnt == spq_pkg::CNT_W'(1)) begin
                                n_cnt = '0;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = spq_pkg::ADDR_W'(1);
                                n_k         = spq_pkg::ADDR_W'(1);
                                n_state     = S_DEL;
                            end
                        end
                        spq_pkg::F_CHANGE: begin
                            if (r_cnt == '0) begin
                                n_status = spq_pkg::ST_NOT_FOUND;
                            end else begin
                                o_ram.re    = 1'b1;
                                o_ram.raddr = '0;
                                n_k         = '0;
                                n_state     = S_SRCH;
                            end
                        end
                        default: begin
                            n_state = S_HEAD;
                        end
                    endcase
                end
            end
            S_INS0: begin
                if (r_cnt == '0) begin
                    n_state = S_PUT;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = spq_pkg::ADDR_W'(r_cnt - 1'b1);
                    n_k         = spq_pkg::ADDR_W'(r_cnt - 1'b1);
                    n_state     = S_INS;
                end
            end
            S_INS: begin
                // scan from the tail, moving lower priorities up one place
                o_ram.we    = 1'b1;
                o_ram.waddr = spq_pkg::ADDR_W'(k_inc);
                if (i_rdata.prio >= r_pr) begin
                    o_ram.wdata = new_entry;
                    n_cnt       = r_cnt + 1'b1;
                    n_state     = S_HEAD;
                end else begin
                    o_ram.wdata = i_rdata;
                    if (r_k == '0) begin
                        n_state = S_PUT;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = r_k - 1'b1;
                        n_k         = r_k - 1'b1;
                    end
                end
            end
            S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = '0;
                o_ram.wdata = new_entry;
                n_cnt       = r_cnt + 1'b1;
                n_state     = S_HEAD;
            end
            S_SRCH: begin
                if (i_rdata.value == r_val) begin
                    if (more) begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = spq_pkg::ADDR_W'(k_inc);
                        n_k         = spq_pkg::ADDR_W'(k_inc);
                        n_state     = S_DEL;
                    end else begin
                        n_cnt   = r_cnt - 1'b1;
                        n_state = S_INS0;
                    end
                end else if (more) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = spq_pkg::ADDR_W'(k_inc);
                    n_k         = spq_pkg::ADDR_W'(k_inc);
                end else begin
                    n_status = spq_pkg::ST_NOT_FOUND;
                    n_state  = S_HEAD;
                end
            end
            S_DEL: begin
                // close the gap: entry k moves down to k-1
                o_ram.we    = 1'b1;
                o_ram.waddr = r_k - 1'b1;
                o_ram.wdata = i_rdata;
                if (more) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = spq_pkg::ADDR_W'(k_inc);
                    n_k         = spq_pkg::ADDR_W'(k_inc);
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = (r_func == spq_pkg::F_CHANGE) ? S_INS0 : S_HEAD;
                end
            end
            S_HEAD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = '0;
                n_state     = S_RES;
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_k      <= '0;
            r_status <= spq_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_k      <= n_k;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_val  <= n_val;
        r_pr   <= n_pr;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_RES);
    assign o_res.head     = (r_cnt == '0) ? '0 : i_rdata.value;
    assign o_res.empty    = (r_cnt == '0);
    assign o_res.count    = r_cnt;
    assign o_res.status   = r_status;

    `SPQ_ASSERT_NEVER(a_no_same_addr, o_ram.we && o_ram.re && (o_ram.waddr == o_ram.raddr));
    `SPQ_ASSERT(a_count_step, (r_cnt != $past(r_cnt)) |-> (({1'b0, r_cnt} == {1'b0, $past(r_cnt)} + 1'b1) || ({1'b0, r_cnt} + 1'b1 == {1'b0, $past(r_cnt)})));
    `SPQ_ASSERT(a_full_flag, (o_ready && i_valid && (i_func == spq_pkg::F_INSERT) && (r_cnt == spq_pkg::CAP_CNT)) |=> (r_status == spq_pkg::ST_FULL));

endmodule

// ===== design/sorted_priority_queue.sv =====
// top level of the sorted priority queue: entry memory, sequencer, result register
// depends on spq_pkg, spq_ram and spq_seq
`timescale 1ns / 1ps

// Sorted priority queue of up to 16 entries (element value and signed priority),
// kept in descending priority order in a single entry memory; equal priorities
// stay first in, first out. One transaction on the input channel carries one
// operation (insert, remove head, change priority, peek) and yields exactly one
// result transaction with the head element, the empty flag, the entry count and
// a status. The memory has one write port and one registered read port, so
// the sequencer moves one entry per cycle and the time an operation takes
// depends on the queue contents: remove depends on the fill count, insert on
// the entries behind the new position, and change on both. A new transaction
// is taken while the previous result still waits in the output register; the
// sequencer holds a finished result until that register is free. There is no
// clearing pass: only entries below the fill count are ever used, and the
// head reads as zero on an empty queue.
module sorted_priority_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // operation channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_func,
    input  logic [spq_pkg::ELEM_W-1:0]  i_elem_value,
    input  logic [spq_pkg::PRIO_W-1:0]  i_prio_value,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [spq_pkg::ELEM_W-1:0]  o_head_element,
    output logic                        o_queue_empty,
    output logic [spq_pkg::CNT_W-1:0]   o_entry_count,
    output logic [1:0]                  o_status
);

    spq_pkg::t_ram_req ram_req;
    spq_pkg::t_entry   rdata;
    spq_pkg::t_result  res;
    logic              res_valid;
    logic              res_ready;

    logic              r_out_valid;
    spq_pkg::t_result  r_out;

    // entry memory, value and priority side by side in one word
    spq_ram #(
        .DEPTH (spq_pkg::CAPACITY),
        .WIDTH (spq_pkg::ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    spq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_elem      (i_elem_value),
        .i_prio      (i_prio_value),
        .o_ram       (ram_req),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register frees the sequencer from the result side
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_head_element = r_out.head;
    assign o_queue_empty  = r_out.empty;
    assign o_entry_count  = r_out.count;
    assign o_status       = r_out.status;

endmodule
